/* sv/assert_macros.svh */
// Assertion helpers for the RTL files; atte_core.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that a condition is never seen on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

/* sv/atte_pkg.sv */
package atte_pkg;

    localparam int FIELD_DIGITS_DEF = 3;
    localparam int CHAR_W = 8;
    localparam int FIELD_W = 10;

    localparam logic [FIELD_W-1:0] FIELD_MAX = 10'd1023;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] value_byte;
        logic              byte_valid;
        logic              search_done;
        logic              status;
    } t_out_item;

    typedef struct packed {
        logic [FIELD_W-1:0] target_tag;
    } t_cfg_item;

    // What the parser produces for one character.
    typedef struct packed {
        logic      emit;
        t_out_item item;
    } t_step_res;

endpackage

/* sv/atte_chan_if.sv */
interface atte_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

/* sv/atte_in_reg.sv */
module atte_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    atte_chan_if.sink           i_in_chan,
    input  logic                i_take,
    output logic                o_valid,
    output atte_pkg::t_in_item  o_item
);

    logic               r_valid;
    atte_pkg::t_in_item r_item;

    // The register refills in the same cycle its beat moves on.
    assign i_in_chan.ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_chan.ready) begin
            r_valid <= i_in_chan.valid;
        end
        if (i_in_chan.valid && i_in_chan.ready) begin
            r_item <= i_in_chan.payload;
        end
    end

endmodule

/* sv/atte_core.sv */
`include "assert_macros.svh"

module atte_core #(
    parameter int FIELD_DIGITS = atte_pkg::FIELD_DIGITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr,
    input  atte_pkg::t_cfg_item i_cfg,
    input  logic                i_step,
    input  atte_pkg::t_in_item  i_item,
    output atte_pkg::t_step_res o_res
);

    localparam int FD_EFF = (FIELD_DIGITS < 1) ? 1 : FIELD_DIGITS;
    localparam int DC_W = (FD_EFF > 1) ? $clog2(FD_EFF) : 1;
    localparam logic [DC_W-1:0] DC_LAST = DC_W'(FD_EFF - 1);

    typedef enum logic [1:0] {
        PH_TAG,
        PH_LEN,
        PH_VAL,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic                         stopped;
        logic [atte_pkg::FIELD_W-1:0] acc;
    } t_digit;

    function automatic t_digit take_digit(
        input logic [atte_pkg::FIELD_W-1:0] acc,
        input logic [atte_pkg::CHAR_W-1:0]  c,
        input logic                         stopped
    );
        t_digit     res;
        logic [13:0] prod;
        res.stopped = stopped;
        res.acc = acc;
        prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {10'd0, c[3:0]};
        if (stopped || c < atte_pkg::CHAR_ZERO || c > atte_pkg::CHAR_NINE) begin
            res.stopped = 1'b1;
        end else if (prod > 14'(atte_pkg::FIELD_MAX)) begin
            res.acc = atte_pkg::FIELD_MAX;
        end else begin
            res.acc = prod[atte_pkg::FIELD_W-1:0];
        end
        return res;
    endfunction

    t_phase                       r_phase, n_phase;
    logic [DC_W-1:0]              r_dc, n_dc;
    logic [atte_pkg::FIELD_W-1:0] r_tag, n_tag;
    logic [atte_pkg::FIELD_W-1:0] r_len, n_len;
    logic                         r_stopped, n_stopped;
    logic                         r_matched, n_matched;
    logic [atte_pkg::FIELD_W-1:0] r_target;

    t_digit                       dig;
    logic [atte_pkg::FIELD_W-1:0] len_dec;
    logic                         field_last;
    logic                         eom;
    logic                         emit, valid, done, notfound;
    logic [atte_pkg::CHAR_W-1:0]  byte_out;

    assign eom = i_item.end_of_message;
    assign field_last = (r_dc == DC_LAST);
    assign dig = take_digit((r_phase == PH_TAG) ? r_tag : r_len, i_item.char_in, r_stopped);
    assign len_dec = (r_len != '0) ? r_len - 1'b1 : r_len;

    always_comb begin
        n_phase = r_phase;
        n_dc = r_dc;
        n_tag = r_tag;
        n_len = r_len;
        n_stopped = r_stopped;
        n_matched = r_matched;
        emit = 1'b0;
        valid = 1'b0;
        done = 1'b0;
        notfound = 1'b0;
        byte_out = '0;

        unique case (r_phase)
            PH_TAG: begin
                n_tag = dig.acc;
                n_stopped = dig.stopped;
                if (field_last) begin
                    n_matched = (dig.acc == r_target);
                    n_phase = PH_LEN;
                    n_dc = '0;
                    n_stopped = 1'b0;
                    n_len = '0;
                end else begin
                    n_dc = r_dc + 1'b1;
                end
            end
            PH_LEN: begin
                n_len = dig.acc;
                n_stopped = dig.stopped;
                if (field_last) begin
                    n_dc = '0;
                    n_stopped = 1'b0;
                    if (dig.acc == '0) begin
                        if (r_matched) begin
                            emit = 1'b1;
                            done = 1'b1;
                        end else begin
                            n_phase = PH_TAG;
                            n_tag = '0;
                        end
                    end else begin
                        n_phase = PH_VAL;
                        if (r_matched && eom) begin
                            emit = 1'b1;
                            done = 1'b1;
                        end
                    end
                end else begin
                    n_dc = r_dc + 1'b1;
                end
            end
            PH_VAL: begin
                n_len = len_dec;
                if (r_matched) begin
                    emit = 1'b1;
                    valid = 1'b1;
                    byte_out = i_item.char_in;
                    done = (len_dec == '0) || eom;
                end else if (len_dec == '0) begin
                    n_phase = PH_TAG;
                    n_dc = '0;
                    n_stopped = 1'b0;
                    n_tag = '0;
                    n_matched = 1'b0;
                end
            end
            PH_SKIP: begin
            end
            default: begin
            end
        endcase

        // A message that ends with the search still open reports not found.
        if (eom && !done && r_phase != PH_SKIP) begin
            emit = 1'b1;
            done = 1'b1;
            notfound = 1'b1;
            valid = 1'b0;
            byte_out = '0;
        end

        if (eom) begin
            n_phase = PH_TAG;
            n_dc = '0;
            n_stopped = 1'b0;
            n_tag = '0;
            n_len = '0;
            n_matched = 1'b0;
        end else if (done) begin
            n_phase = PH_SKIP;
        end
    end

    assign o_res.emit = emit;
    assign o_res.item.value_byte = byte_out;
    assign o_res.item.byte_valid = valid;
    assign o_res.item.search_done = done;
    assign o_res.item.status = notfound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_dc <= '0;
            r_tag <= '0;
            r_len <= '0;
            r_stopped <= 1'b0;
            r_matched <= 1'b0;
            r_target <= '0;
        end else begin
            if (i_step) begin
                r_phase <= n_phase;
                r_dc <= n_dc;
                r_tag <= n_tag;
                r_len <= n_len;
                r_stopped <= n_stopped;
                r_matched <= n_matched;
            end
            if (i_cfg_wr) begin
                r_target <= i_cfg.target_tag;
            end
        end
    end

    `ASSERT_CLK(a_skip_silent, i_clk, i_rst_n, (i_step && r_phase == PH_SKIP) |-> !o_res.emit, "result produced after the search ended")
    `ASSERT_CLK(a_notfound_empty, i_clk, i_rst_n, (o_res.emit && o_res.item.status) |-> (o_res.item.search_done && !o_res.item.byte_valid), "not-found result carries a value byte")
    `ASSERT_CLK(a_done_parks, i_clk, i_rst_n, (i_step && o_res.item.search_done && !eom) |=> (r_phase == PH_SKIP), "search ended but parser still scanning")

endmodule

/* sv/atte_out_reg.sv */
module atte_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  atte_pkg::t_out_item i_item,
    output logic                o_can_load,
    atte_chan_if.source         o_out_chan
);

    logic                r_valid;
    atte_pkg::t_out_item r_item;

    assign o_can_load = !r_valid || o_out_chan.ready;
    assign o_out_chan.valid = r_valid;
    assign o_out_chan.payload = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out_chan.ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_item <= i_item;
        end
    end

endmodule

/* sv/ascii_tlv_tag_extractor_unit.sv */
// A character waits in the input register; its result is offered from the output register.
// Throughput: one character per cycle, stalls aside; the parser steps once per character.
// A character whose result finds the output register still held waits in the input register.
// Reset (i_rst_n low, synchronous) empties both registers, sets the target tag to 0
// and puts the parser at the start of a tag field.
module ascii_tlv_tag_extractor_unit #(
    parameter int FIELD_DIGITS = atte_pkg::FIELD_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    atte_chan_if.sink   i_in_chan,
    atte_chan_if.sink   i_cfg_chan,
    atte_chan_if.source o_out_chan
);

    logic                item_valid;
    atte_pkg::t_in_item  item;
    atte_pkg::t_step_res res;
    logic                can_load;
    logic                take;

    // A character with no result moves on even while the output is held.
    assign take = item_valid && (!res.emit || can_load);
    assign i_cfg_chan.ready = 1'b1;

    atte_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_chan (i_in_chan),
        .i_take    (take),
        .o_valid   (item_valid),
        .o_item    (item)
    );

    atte_core #(
        .FIELD_DIGITS (FIELD_DIGITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (i_cfg_chan.valid),
        .i_cfg    (i_cfg_chan.payload),
        .i_step   (take),
        .i_item   (item),
        .o_res    (res)
    );

    atte_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take && res.emit),
        .i_item     (res.item),
        .o_can_load (can_load),
        .o_out_chan (o_out_chan)
    );

endmodule
